// File: rtl/srca_pkg.sv
// Package for the shared ring channel ack engine: types, codes and helpers.
`default_nettype none
package srca_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int CFG_W = 7;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_LINE_BYTES = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACK_WMARK  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam logic [1:0] RG_TX_MSG = 2'd0;
    localparam logic [1:0] RG_TX_ACK = 2'd1;
    localparam logic [1:0] RG_RX_MSG = 2'd2;
    localparam logic [1:0] RG_RX_ACK = 2'd3;

    localparam logic [1:0] TYPE_ACKS    = 2'd1;
    localparam logic [1:0] TYPE_MSG     = 2'd2;
    localparam logic [1:0] TYPE_MSG_ACK = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ack_meta_seen;
        logic [7:0] msg_meta_seen;
    } srca_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] region;
        logic [5:0] slot_index;
        logic [5:0] byte_offset;
        logic [7:0] write_value;
        logic       write_valid;
        logic       last;
    } srca_out_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ONE, S_TX_ACK, S_TX_MSG, S_RX_MSG, S_RX_BYTE, S_RX_META
    } srca_state_t;

    typedef struct packed {
        srca_state_t sel;
        logic        load;
        logic        decode;
        logic        step;
    } srca_cmd_t;

    typedef struct packed {
        logic cmd;
        logic ack_nonzero;
        logic bad_ack;
        logic rx_empty;
        logic rx_bad;
        logic tx_full;
        logic ack_pred;
        logic byte_last;
    } srca_stat_t;

    // Ring size in use: clamp to the maximum, round down to a power of two, at least 8.
    function automatic logic [6:0] eff_slots(input logic [6:0] sc, input logic [6:0] mx);
        logic [6:0] c;
        logic [6:0] s;
        c = (sc > mx) ? mx : sc;
        s = 7'd8;
        for (int k = 4; k <= 6; k++) begin
            if ((7'd1 << k) <= c) begin
                s = 7'd1 << k;
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/srca_ctrl.sv
// Controller state machine: sequences the result run of one transaction.
`default_nettype none
module srca_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire srca_pkg::srca_stat_t stat,
    output srca_pkg::srca_cmd_t     ctl
);
    srca_pkg::srca_state_t state_reg, state_next;
    logic take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srca_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        take       = m_ready;
        ctl.sel    = state_reg;
        ctl.load   = 1'b0;
        ctl.decode = 1'b0;
        ctl.step   = 1'b0;
        case (state_reg)
            srca_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
                if (s_valid) state_next = srca_pkg::S_DECODE;
            end
            srca_pkg::S_DECODE: begin
                ctl.decode = 1'b1;
                if (!stat.cmd) begin
                    if (stat.bad_ack)          state_next = srca_pkg::S_ONE;
                    else if (stat.ack_nonzero) state_next = srca_pkg::S_TX_ACK;
                    else                       state_next = srca_pkg::S_TX_MSG;
                end else begin
                    if (stat.rx_empty || stat.rx_bad) state_next = srca_pkg::S_ONE;
                    else                              state_next = srca_pkg::S_RX_MSG;
                end
            end
            srca_pkg::S_ONE, srca_pkg::S_TX_MSG, srca_pkg::S_RX_META: begin
                m_valid  = 1'b1;
                ctl.step = take;
                if (take) state_next = srca_pkg::S_IDLE;
            end
            srca_pkg::S_TX_ACK: begin
                m_valid  = 1'b1;
                ctl.step = take;
                if (take) state_next = srca_pkg::S_TX_MSG;
            end
            srca_pkg::S_RX_MSG: begin
                m_valid  = 1'b1;
                ctl.step = take;
                if (take) state_next = stat.ack_pred ? srca_pkg::S_RX_BYTE : srca_pkg::S_IDLE;
            end
            srca_pkg::S_RX_BYTE: begin
                m_valid  = 1'b1;
                ctl.step = take;
                if (take && stat.byte_last) state_next = srca_pkg::S_RX_META;
            end
            default: state_next = srca_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/srca_dp.sv
// Datapath: configuration, ring pointers and counters, result formatting.
`default_nettype none
module srca_dp #(
    parameter int MAX_SLOTS = srca_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [srca_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [srca_pkg::CFG_W-1:0] cfg_data,
    input  wire srca_pkg::srca_in_t         s_data,
    input  wire srca_pkg::srca_cmd_t        ctl,
    output srca_pkg::srca_stat_t            stat,
    output srca_pkg::srca_out_t             m_data
);
    localparam logic [6:0] MAX_S = 7'(MAX_SLOTS);

    logic [6:0] slot_count_reg, line_bytes_reg;
    logic [5:0] ack_wm_reg;
    srca_pkg::srca_in_t in_reg;
    logic [1:0] st_reg;
    logic [6:0] tx_free_reg, tx_owed_reg, rx_free_reg, rx_owed_reg;
    logic [5:0] tx_msg_ptr_reg, tx_ackslot_ptr_reg, tx_msg_ack_ptr_reg, tx_ackslot_ack_ptr_reg;
    logic [5:0] rx_msg_ptr_reg, rx_ackslot_ptr_reg, rx_msg_ack_ptr_reg, rx_ackslot_ack_ptr_reg;
    logic [5:0] n_reg, cnt_reg;

    logic [6:0] s, ls;
    logic [5:0] m, metaoff, lmax, wm;
    logic [5:0] tx_map, tx_amp, tx_aap, tx_mp, rx_mp, rx_ap, rx_map, rx_aap;
    logic [5:0] n_tx;
    logic [7:0] tx_sum;
    logic [6:0] tx_free_rel, tx_free_after, tx_owed_inc;
    logic       rx_c0;
    logic [6:0] rx_free_inc, rx_owed_inc;
    logic [5:0] n_rx;
    logic       pred;

    always_comb begin
        s       = srca_pkg::eff_slots(slot_count_reg, MAX_S);
        m       = 6'(s - 7'd1);
        ls      = (line_bytes_reg < 7'd8) ? 7'd8
                : ((line_bytes_reg > 7'd64) ? 7'd64 : line_bytes_reg);
        metaoff = 6'(ls - 7'd1);
        lmax    = 6'(ls - 7'd2);
        wm      = (ack_wm_reg == 6'd0) ? 6'd1 : ack_wm_reg;
        tx_mp   = tx_msg_ptr_reg & m;
        tx_amp  = tx_ackslot_ptr_reg & m;
        tx_map  = tx_msg_ack_ptr_reg & m;
        tx_aap  = tx_ackslot_ack_ptr_reg & m;
        rx_mp   = rx_msg_ptr_reg & m;
        rx_ap   = rx_ackslot_ptr_reg & m;
        rx_map  = rx_msg_ack_ptr_reg & m;
        rx_aap  = rx_ackslot_ack_ptr_reg & m;

        // send: release of acked message slots
        n_tx        = in_reg.ack_meta_seen[5:0];
        tx_sum      = {1'b0, tx_free_reg} + {2'b00, n_tx};
        tx_free_rel = (tx_free_reg >= s) ? tx_free_reg
                    : ((tx_sum > {1'b0, s}) ? s : tx_sum[6:0]);
        tx_free_after = (in_reg.ack_meta_seen != 8'd0) ? tx_free_rel : tx_free_reg;
        tx_owed_inc = (tx_owed_reg == 7'd127) ? tx_owed_reg : tx_owed_reg + 7'd1;

        // receive: prospective ack-slot decision after this message
        rx_c0       = (in_reg.msg_meta_seen[7:6] == srca_pkg::TYPE_MSG_ACK);
        rx_free_inc = (rx_c0 && rx_free_reg < s) ? rx_free_reg + 7'd1 : rx_free_reg;
        rx_owed_inc = (rx_owed_reg == 7'd127) ? rx_owed_reg : rx_owed_reg + 7'd1;
        pred        = (rx_free_inc != 7'd0) && (rx_owed_inc >= {1'b0, wm});
        n_rx        = (rx_owed_inc > {1'b0, lmax}) ? lmax : rx_owed_inc[5:0];

        stat.cmd         = in_reg.cmd;
        stat.ack_nonzero = (in_reg.ack_meta_seen != 8'd0);
        stat.bad_ack     = stat.ack_nonzero && (in_reg.ack_meta_seen[7:6] != srca_pkg::TYPE_ACKS);
        stat.rx_empty    = (in_reg.msg_meta_seen == 8'd0);
        stat.rx_bad      = (in_reg.msg_meta_seen[7:6] != srca_pkg::TYPE_MSG) && !rx_c0;
        stat.tx_full     = (tx_free_reg == 7'd0);
        stat.ack_pred    = pred;
        stat.byte_last   = (cnt_reg == n_reg - 6'd1);
    end

    always_comb begin
        m_data.status      = st_reg;
        m_data.region      = srca_pkg::RG_TX_MSG;
        m_data.slot_index  = tx_mp;
        m_data.byte_offset = 6'd0;
        m_data.write_value = 8'd0;
        m_data.write_valid = 1'b0;
        m_data.last        = 1'b1;
        case (ctl.sel)
            srca_pkg::S_ONE: begin
                m_data.region     = in_reg.cmd ? srca_pkg::RG_RX_MSG : srca_pkg::RG_TX_ACK;
                m_data.slot_index = in_reg.cmd ? rx_mp : tx_amp;
            end
            srca_pkg::S_TX_ACK: begin
                m_data.region      = srca_pkg::RG_TX_ACK;
                m_data.slot_index  = tx_amp;
                m_data.byte_offset = metaoff;
                m_data.write_valid = 1'b1;
                m_data.last        = 1'b0;
            end
            srca_pkg::S_TX_MSG: begin
                if (!stat.tx_full) begin
                    m_data.byte_offset = metaoff;
                    m_data.write_valid = 1'b1;
                    m_data.write_value = (tx_owed_reg != 7'd0)
                                       ? {srca_pkg::TYPE_MSG_ACK, tx_aap}
                                       : {srca_pkg::TYPE_MSG, 6'd0};
                end
            end
            srca_pkg::S_RX_MSG: begin
                m_data.region      = srca_pkg::RG_RX_MSG;
                m_data.slot_index  = rx_mp;
                m_data.byte_offset = metaoff;
                m_data.write_valid = 1'b1;
                m_data.last        = !pred;
            end
            srca_pkg::S_RX_BYTE: begin
                m_data.region      = srca_pkg::RG_RX_ACK;
                m_data.slot_index  = rx_ap;
                m_data.byte_offset = cnt_reg;
                m_data.write_value = {2'b00, (rx_map + cnt_reg) & m};
                m_data.write_valid = 1'b1;
                m_data.last        = 1'b0;
            end
            srca_pkg::S_RX_META: begin
                m_data.region      = srca_pkg::RG_RX_ACK;
                m_data.slot_index  = rx_ap;
                m_data.byte_offset = metaoff;
                m_data.write_value = {srca_pkg::TYPE_ACKS, n_reg};
                m_data.write_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) in_reg <= s_data;
        if (ctl.decode) begin
            if (!in_reg.cmd) begin
                st_reg <= stat.bad_ack ? srca_pkg::ST_BAD
                        : ((tx_free_after == 7'd0) ? srca_pkg::ST_FULL : srca_pkg::ST_OK);
            end else begin
                st_reg <= stat.rx_empty ? srca_pkg::ST_EMPTY
                        : (stat.rx_bad ? srca_pkg::ST_BAD : srca_pkg::ST_OK);
            end
        end
        if (ctl.step && ctl.sel == srca_pkg::S_RX_MSG) begin
            n_reg   <= n_rx;
            cnt_reg <= 6'd0;
        end
        if (ctl.step && ctl.sel == srca_pkg::S_RX_BYTE) cnt_reg <= cnt_reg + 6'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg         <= 7'd32;
            line_bytes_reg         <= 7'd64;
            ack_wm_reg             <= 6'd8;
            tx_free_reg            <= 7'd32;
            tx_owed_reg            <= 7'd0;
            rx_free_reg            <= 7'd32;
            rx_owed_reg            <= 7'd0;
            tx_msg_ptr_reg         <= 6'd0;
            tx_ackslot_ptr_reg     <= 6'd0;
            tx_msg_ack_ptr_reg     <= 6'd0;
            tx_ackslot_ack_ptr_reg <= 6'd0;
            rx_msg_ptr_reg         <= 6'd0;
            rx_ackslot_ptr_reg     <= 6'd0;
            rx_msg_ack_ptr_reg     <= 6'd0;
            rx_ackslot_ack_ptr_reg <= 6'd0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    srca_pkg::REG_SLOT_COUNT: slot_count_reg <= cfg_data;
                    srca_pkg::REG_LINE_BYTES: line_bytes_reg <= cfg_data;
                    srca_pkg::REG_ACK_WMARK:  ack_wm_reg     <= cfg_data[5:0];
                    default: ;
                endcase
            end
            // every transaction folds all pointers into the ring size in use
            if (ctl.decode) begin
                tx_msg_ptr_reg         <= tx_mp;
                tx_ackslot_ptr_reg     <= tx_amp;
                tx_msg_ack_ptr_reg     <= tx_map;
                tx_ackslot_ack_ptr_reg <= tx_aap;
                rx_msg_ptr_reg         <= rx_mp;
                rx_ackslot_ptr_reg     <= rx_ap;
                rx_msg_ack_ptr_reg     <= rx_map;
                rx_ackslot_ack_ptr_reg <= rx_aap;
            end
            if (ctl.step) begin
                case (ctl.sel)
                    srca_pkg::S_TX_ACK: begin
                        tx_free_reg        <= tx_free_rel;
                        tx_msg_ack_ptr_reg <= (tx_map + n_tx) & m;
                        tx_owed_reg        <= tx_owed_inc;
                        tx_ackslot_ptr_reg <= (tx_amp + 6'd1) & m;
                    end
                    srca_pkg::S_TX_MSG: begin
                        if (!stat.tx_full) begin
                            if (tx_owed_reg != 7'd0) begin
                                tx_owed_reg            <= tx_owed_reg - 7'd1;
                                tx_ackslot_ack_ptr_reg <= (tx_aap + 6'd1) & m;
                            end
                            tx_msg_ptr_reg <= (tx_mp + 6'd1) & m;
                            tx_free_reg    <= tx_free_reg - 7'd1;
                        end
                    end
                    srca_pkg::S_RX_MSG: begin
                        if (rx_c0) rx_ackslot_ack_ptr_reg <= (rx_aap + 6'd1) & m;
                        rx_free_reg    <= rx_free_inc;
                        rx_owed_reg    <= rx_owed_inc;
                        rx_msg_ptr_reg <= (rx_mp + 6'd1) & m;
                    end
                    srca_pkg::S_RX_META: begin
                        rx_msg_ack_ptr_reg <= (rx_map + n_reg) & m;
                        rx_owed_reg        <= rx_owed_reg - {1'b0, n_reg};
                        rx_ackslot_ptr_reg <= (rx_ap + 6'd1) & m;
                        rx_free_reg        <= rx_free_reg - 7'd1;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/shared_ring_channel_ack_engine.sv
// Top level of the shared ring channel ack engine: controller plus datapath.
//
//  channel  dir  handshake           payload
//  s_       in   s_valid / s_ready   srca_in_t  (cmd, ack/msg meta seen)
//  m_       out  m_valid / m_ready   srca_out_t (at most one memory write per result)
//  cfg_     in   cfg_wr_en           cfg_index, cfg_data (no wait, no read-back)
//
// Sequence: a transaction is accepted, then decoded, then its results are emitted;
// a receive that writes an ack slot emits 2 + n results (n <= clamped line bytes - 2).
// The result sequencer emits one result per cycle while m_ready is high and sets the rate.
// Reset: aresetn synchronous, low; config back to 32/64/8, free counts to 32, owed counts and pointers cleared.
// Stalls: m_ready low holds the current result; s_ready is high only when idle.
`default_nettype none
module shared_ring_channel_ack_engine #(
    parameter int MAX_SLOTS = srca_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [srca_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [srca_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire srca_pkg::srca_in_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output srca_pkg::srca_out_t             m_data
);
    srca_pkg::srca_cmd_t  ctl;
    srca_pkg::srca_stat_t stat;

    srca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    srca_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .ctl       (ctl),
        .stat      (stat),
        .m_data    (m_data)
    );

    // Never taking a new transaction while a result run is in flight.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken during result run");

    // A result without a write always ends its run.
    a_nowrite_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.write_valid) |-> m_data.last)
        else $error("write-less result not last");

    // Writes only come with ok or full status.
    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_valid) |->
        (m_data.status == srca_pkg::ST_OK || m_data.status == srca_pkg::ST_FULL))
        else $error("write with error status");

    // A taken non-final result keeps the engine busy.
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> !s_ready)
        else $error("run ended early");
endmodule
`default_nettype wire
